>>> src/fixed_point_dda_line_rasterizer_assert.svh
// Assertion helpers shared by the rasterizer modules.
`ifndef FIXED_POINT_DDA_LINE_RASTERIZER_ASSERT_SVH
`define FIXED_POINT_DDA_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define FPDDA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rasterizer same-cycle check failed");

// Next-cycle implication, off during reset.
`define FPDDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rasterizer next-cycle check failed");

`endif

>>> src/fpdda_pkg.sv
`default_nettype none

package fpdda_pkg;

  localparam int FIELD_BITS = 16;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } item_op_t;

  // Datapath operation selected by the current control word.
  typedef enum logic [2:0] {
    DP_DISPATCH,
    DP_DELTA,
    DP_SELECT,
    DP_DIVIDE,
    DP_FINISH
  } dp_op_t;

  typedef enum logic [1:0] {
    JMP_ALWAYS,
    JMP_DISPATCH,
    JMP_DIV_DONE,
    JMP_OUT_FREE
  } jump_t;

  typedef enum logic [2:0] {
    STEP_DISPATCH,
    STEP_DELTA,
    STEP_SELECT,
    STEP_DIVIDE,
    STEP_FINISH
  } step_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
    jump_t  jump;
    step_t  target;
  } ucode_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
  } dp_ctrl_t;

  typedef struct packed {
    logic accept_start;
    logic div_last;
    logic out_free;
  } dp_status_t;

  // Control store. A conditional jump that is not taken holds the step.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      STEP_DISPATCH: w = '{op: DP_DISPATCH, in_ready: 1'b1, jump: JMP_DISPATCH,
                           target: STEP_DELTA};
      STEP_DELTA:    w = '{op: DP_DELTA, in_ready: 1'b0, jump: JMP_ALWAYS,
                           target: STEP_SELECT};
      STEP_SELECT:   w = '{op: DP_SELECT, in_ready: 1'b0, jump: JMP_ALWAYS,
                           target: STEP_DIVIDE};
      STEP_DIVIDE:   w = '{op: DP_DIVIDE, in_ready: 1'b0, jump: JMP_DIV_DONE,
                           target: STEP_FINISH};
      STEP_FINISH:   w = '{op: DP_FINISH, in_ready: 1'b0, jump: JMP_OUT_FREE,
                           target: STEP_DISPATCH};
      default:       w = '{op: DP_DISPATCH, in_ready: 1'b1, jump: JMP_DISPATCH,
                           target: STEP_DELTA};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/fpdda_in_if.sv
`default_nettype none

interface fpdda_in_if;
  import fpdda_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [FIELD_BITS-1:0] x_start;
  logic [FIELD_BITS-1:0] y_start;
  logic [FIELD_BITS-1:0] x_end;
  logic [FIELD_BITS-1:0] y_end;

  modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

`default_nettype wire

>>> src/fpdda_out_if.sv
`default_nettype none

interface fpdda_out_if;
  import fpdda_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] pixel_x;
  logic [FIELD_BITS-1:0] pixel_y;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

`default_nettype wire

>>> src/fixed_point_dda_line_rasterizer.sv
// Channel  Dir  Payload                               Accepted when
// cmd      in   op, x_start, y_start, x_end, y_end    cmd.valid && cmd.ready
// pix      out  pixel_x, pixel_y, last                pix.valid && pix.ready
//
// Advance items step position and accumulator and compare with the limit,
// one pixel per cycle while pix is taken. A start item runs the DELTA,
// SELECT, DIVIDE and FINISH steps; the restoring divider makes one quotient
// bit per cycle for the minor increment. There is no clearing pass on reset.
// A full output register that is not taken holds cmd.ready low.
`default_nettype none

module fixed_point_dda_line_rasterizer
  import fpdda_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  fpdda_in_if.sink    cmd,
  fpdda_out_if.source pix
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  fpdda_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  fpdda_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .status (status),
    .cmd    (cmd),
    .pix    (pix)
  );

endmodule

`default_nettype wire

>>> src/fpdda_seq.sv
`default_nettype none
`include "fixed_point_dda_line_rasterizer_assert.svh"

module fpdda_seq
  import fpdda_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output dp_ctrl_t   ctrl
);

  step_t  step;
  step_t  step_next;
  ucode_t word;

  assign word = ucode_rom(step);

  always_comb begin
    step_next = step;
    case (word.jump)
      JMP_ALWAYS:   step_next = word.target;
      JMP_DISPATCH: if (status.accept_start) step_next = word.target;
      JMP_DIV_DONE: if (status.div_last) step_next = word.target;
      JMP_OUT_FREE: if (status.out_free) step_next = word.target;
      default:      step_next = STEP_DISPATCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_DISPATCH;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl.op       = word.op;
    ctrl.in_ready = word.in_ready;
  end

  `FPDDA_ASSERT_NEXT(a_start_runs_delta, clk, rst, status.accept_start, step == STEP_DELTA)
  `FPDDA_ASSERT_NEXT(a_finish_holds, clk, rst, step == STEP_FINISH && !status.out_free, step == STEP_FINISH)

endmodule

`default_nettype wire

>>> src/fpdda_dp.sv
`default_nettype none
`include "fixed_point_dda_line_rasterizer_assert.svh"

module fpdda_dp
  import fpdda_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_ctrl_t           ctrl,
  output dp_status_t         status,
  fpdda_in_if.sink           cmd,
  fpdda_out_if.source        pix
);

  localparam int C        = COORD_BITS;
  localparam int F        = FRAC_BITS;
  localparam int ACC_BITS = C + F + 2;
  localparam int INC_BITS = F + 2;
  localparam int QUO_BITS = F + 1;
  localparam int CNT_BITS = $clog2(F + 1);
  localparam logic [F-1:0] HALF_PIXEL = {1'b1, {(F-1){1'b0}}};
  localparam logic signed [INC_BITS-1:0] INC_MAX = {2'b01, {F{1'b0}}};

  // endpoints
  logic [C-1:0] x0, y0, x1, y1;
  // deltas
  logic [C-1:0] adx, ady;
  logic         dx_neg, dy_neg;
  // line state
  logic                       active;
  logic                       major_is_y;
  logic                       descending;
  logic [C-1:0]               position;
  logic [C-1:0]               limit;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [INC_BITS-1:0] inc;
  // divider
  logic [C:0]          rem;
  logic [C-1:0]        dvs;
  logic [QUO_BITS-1:0] quo;
  logic [CNT_BITS-1:0] cnt;
  logic                q_neg;
  logic                maj_zero;
  // output register
  logic         out_valid;
  logic [C-1:0] out_x, out_y;
  logic         out_last;

  logic accept, accept_start, accept_adv, out_free, out_load;
  logic [C:0]   dx_w, dy_w, dx_mag, dy_mag;
  logic         y_major_w, maj_neg_w, min_neg_w;
  logic [C-1:0] amaj_w, amin_w, min0_w, pos0_w, lim0_w;
  logic signed [ACC_BITS-1:0] acc_init;
  logic [C+1:0] diff;
  logic         ge;
  logic [C:0]   r_keep, rem_next;
  logic signed [INC_BITS-1:0] inc_mag, inc_fin;
  logic [C-1:0] pos_adv;
  logic signed [ACC_BITS-1:0] inc_ext, acc_adv;
  logic [C-1:0] emit_pos, emit_minor;
  logic signed [ACC_BITS-1:0] emit_acc;
  logic         last_w;

  assign out_free     = !out_valid || pix.ready;
  assign cmd.ready    = ctrl.in_ready && out_free;
  assign accept       = cmd.valid && cmd.ready;
  assign accept_start = accept && (cmd.op == OP_START);
  assign accept_adv   = accept && (cmd.op == OP_ADVANCE) && active;
  assign out_load     = ((ctrl.op == DP_FINISH) && out_free) || accept_adv;

  always_comb begin
    status.accept_start = accept_start;
    status.div_last     = (cnt == '0);
    status.out_free     = out_free;
  end

  // deltas and magnitudes
  assign dx_w   = {1'b0, x1} - {1'b0, x0};
  assign dy_w   = {1'b0, y1} - {1'b0, y0};
  assign dx_mag = dx_w[C] ? (~dx_w + 1'b1) : dx_w;
  assign dy_mag = dy_w[C] ? (~dy_w + 1'b1) : dy_w;

  // major axis pick; a tie goes to x
  assign y_major_w = ady > adx;
  assign amaj_w    = y_major_w ? ady : adx;
  assign amin_w    = y_major_w ? adx : ady;
  assign maj_neg_w = y_major_w ? dy_neg : dx_neg;
  assign min_neg_w = y_major_w ? dx_neg : dy_neg;
  assign min0_w    = y_major_w ? x0 : y0;
  assign pos0_w    = y_major_w ? y0 : x0;
  assign lim0_w    = y_major_w ? y1 : x1;
  assign acc_init  = signed'({2'b00, min0_w, HALF_PIXEL});

  // restoring divider, one quotient bit per step; the remainder is shifted left after each trial subtraction
  assign diff     = {1'b0, rem} - {2'b00, dvs};
  assign ge       = !diff[C+1];
  assign r_keep   = ge ? diff[C:0] : rem;
  assign rem_next = {r_keep[C-1:0], 1'b0};

  assign inc_mag = signed'({1'b0, quo});
  assign inc_fin = maj_zero ? '0 : (q_neg ? -inc_mag : inc_mag);

  // one pixel step
  assign pos_adv = descending ? (position - 1'b1) : (position + 1'b1);
  assign inc_ext = ACC_BITS'(inc);
  assign acc_adv = descending ? (acc - inc_ext) : (acc + inc_ext);

  assign emit_pos   = (ctrl.op == DP_FINISH) ? position : pos_adv;
  assign emit_acc   = (ctrl.op == DP_FINISH) ? acc : acc_adv;
  assign emit_minor = emit_acc[F +: C];
  assign last_w     = (emit_pos == limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      major_is_y <= 1'b0;
      descending <= 1'b0;
      inc        <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        DP_DISPATCH: begin
          if (accept_adv) active <= !last_w;
        end
        DP_SELECT: begin
          major_is_y <= y_major_w;
          descending <= maj_neg_w || (amaj_w == '0);
          cnt        <= CNT_BITS'(F);
        end
        DP_DIVIDE: begin
          cnt <= cnt - 1'b1;
        end
        DP_FINISH: begin
          if (out_free) begin
            inc    <= inc_fin;
            active <= !last_w;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept_start) begin
      x0 <= cmd.x_start[C-1:0];
      y0 <= cmd.y_start[C-1:0];
      x1 <= cmd.x_end[C-1:0];
      y1 <= cmd.y_end[C-1:0];
    end
    if (out_load) begin
      out_x    <= major_is_y ? emit_minor : emit_pos;
      out_y    <= major_is_y ? emit_pos : emit_minor;
      out_last <= last_w;
    end
    case (ctrl.op)
      DP_DISPATCH: begin
        if (accept_adv) begin
          position <= pos_adv;
          acc      <= acc_adv;
        end
      end
      DP_DELTA: begin
        adx    <= dx_mag[C-1:0];
        ady    <= dy_mag[C-1:0];
        dx_neg <= dx_w[C];
        dy_neg <= dy_w[C];
      end
      DP_SELECT: begin
        position <= pos0_w;
        limit    <= lim0_w;
        acc      <= acc_init;
        rem      <= {1'b0, amin_w};
        dvs      <= amaj_w;
        quo      <= '0;
        q_neg    <= maj_neg_w ^ min_neg_w;
        maj_zero <= (amaj_w == '0);
      end
      DP_DIVIDE: begin
        rem <= rem_next;
        quo <= {quo[QUO_BITS-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  assign pix.valid   = out_valid;
  assign pix.pixel_x = FIELD_BITS'(out_x);
  assign pix.pixel_y = FIELD_BITS'(out_y);
  assign pix.last    = out_last;

  `FPDDA_ASSERT_NEXT(a_last_ends_line, clk, rst, out_load && last_w, !active)
  `FPDDA_ASSERT_IMPLIES(a_inc_bounded, clk, rst, active, (inc <= INC_MAX) && (inc >= -INC_MAX))
  `FPDDA_ASSERT_NEXT(a_div_to_finish, clk, rst, ctrl.op == DP_DIVIDE && status.div_last, ctrl.op == DP_FINISH)

endmodule

`default_nettype wire
